// ===== hdl/sha256_pkg.sv =====
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds = 64;
  localparam int unsigned CountWidth = 61;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } comp_ctl_t;

  localparam word_t InitWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hdl/sha256_round.sv =====
`timescale 1ns / 1ps
module sha256_round (
  input  logic clk,
  input  sha256_pkg::comp_ctl_t ctl,
  input  logic [5:0] round_idx,
  input  sha256_pkg::word_t load_words [16],
  input  sha256_pkg::word_t chain [8],
  output sha256_pkg::word_t work [8]
);
  import sha256_pkg::*;

  word_t w [16];
  word_t v [8];
  word_t w_new, wt, s0, s1, t1, t2;

  // Message schedule as a 16-word shift line; word t is always w[0].
  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    wt = w[0];
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(round_idx) + wt;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      w <= load_words;
      v <= chain;
    end else if (ctl.busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  assign work = v;
endmodule

// ===== hdl/sha256_message_hasher.sv =====
`timescale 1ns / 1ps
// SHA-256 over a byte stream. Each input transfer carries one byte (when
// tuser has_byte is set) and tlast as end-of-message. Byte transfers are
// accepted in the idle state; the one that fills a 64-byte block then holds
// off the input while one shared round unit runs 64 rounds, one per
// cycle, and the chain words fold in. An end transfer pads the message in
// one or two more blocks (a pad step, then the rounds and the fold, per block)
// and then delivers the digest as four 64-bit transfers, part 0 first, tlast
// on part 3; the hasher then restarts with the initial hash values. tready
// is low throughout compression and digest output.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // has_byte
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // digest_part[63:0], part_index[65:64], zeros
  output logic        m_tlast    // last_part
);
  import sha256_pkg::*;

  state_t state, state_next;
  word_t chain [8];
  word_t work [8];
  // Block buffer as big-endian words: byte 4*j sits in the top lane of word j.
  word_t buffer [BlockBytes/4];
  word_t pad_block [BlockBytes/4];
  logic [CountWidth-1:0] byte_count;
  logic [6:0] round_cnt;
  logic       final_block;  // running the block that holds the length
  logic       finishing;    // message end seen, padding pending
  logic       pad_done;     // pad byte already placed, second block is zero but for the length
  logic       len_fits;     // length goes into the block being padded
  logic [1:0] part;
  logic       accept, out_fire;
  comp_ctl_t  ctl;
  logic [CountWidth+2:0] bit_len;

  assign accept = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign bit_len = {byte_count, 3'b000};
  assign len_fits = pad_done || (byte_count[5:0] < 6'd56);

  // Padded image of the buffer: keep the message bytes, place the pad byte,
  // clear the rest (all of it once the pad byte is placed) and drop in the bit length when it fits.
  always_comb begin
    for (int j = 0; j < BlockBytes/4; j++) begin
      for (int b = 0; b < 4; b++) begin
        if (pad_done || 6'(4*j+b) > byte_count[5:0])
          pad_block[j][8*(3-b) +: 8] = 8'h00;
        else if (6'(4*j+b) == byte_count[5:0])
          pad_block[j][8*(3-b) +: 8] = PadByte;
        else
          pad_block[j][8*(3-b) +: 8] = buffer[j][8*(3-b) +: 8];
      end
    end
    if (len_fits) begin
      pad_block[14] = bit_len[63:32];
      pad_block[15] = bit_len[31:0];
    end
  end

  sha256_round u_round (
    .clk(clk), .ctl(ctl), .round_idx(round_cnt[5:0]),
    .load_words(buffer), .chain(chain), .work(work)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser && (byte_count[5:0] == 6'd63)) state_next = ST_LOAD;
          else if (s_tlast) state_next = ST_PAD;
        end
      end
      ST_PAD:   state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: if (round_cnt == 7'(Rounds - 1)) state_next = ST_FOLD;
      ST_FOLD: begin
        if (final_block) state_next = ST_OUT;
        else if (finishing) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_OUT:   if (out_fire && part == 2'd3) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    s_tready = (state == ST_IDLE);
    ctl.start = (state == ST_LOAD);
    ctl.busy = (state == ST_ROUND);
    m_tvalid = (state == ST_OUT);
    m_tlast = (part == 2'd3);
    m_tdata = {6'd0, part, chain[{part, 1'b0}], chain[{part, 1'b1}]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      byte_count <= '0;
      round_cnt <= '0;
      final_block <= 1'b0;
      finishing <= 1'b0;
      pad_done <= 1'b0;
      part <= '0;
      chain <= InitWords;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              buffer[byte_count[5:2]][{~byte_count[1:0], 3'b000} +: 8] <= s_tdata;
              byte_count <= byte_count + 1'b1;
            end
            finishing <= s_tlast;
          end
        end
        ST_PAD: begin
          buffer <= pad_block;
          if (len_fits) final_block <= 1'b1;
          pad_done <= 1'b1;
        end
        ST_LOAD:  round_cnt <= '0;
        ST_ROUND: round_cnt <= round_cnt + 1'b1;
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + work[i];
        end
        ST_OUT: begin
          if (out_fire) begin
            part <= part + 1'b1;
            if (part == 2'd3) begin
              chain <= InitWords;
              byte_count <= '0;
              final_block <= 1'b0;
              finishing <= 1'b0;
              pad_done <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input open during digest output");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOLD) |-> $past(round_cnt) == 7'(Rounds - 1))
    else $error("fold without full round count");
  assert property (@(posedge clk) disable iff (rst)
    (out_fire && part == 2'd3) |=> (byte_count == '0) && !m_tvalid)
    else $error("hasher did not restart after digest");
endmodule
